/* hw/rtl/spc_pkg.sv */
// ============================================================================
// spc_pkg: shared types and constants of the skin pixel classifier.
// Fixed-point coefficients of the YCrCb conversion, the chroma line bounds,
// the RGB rule thresholds and the register map.
// ============================================================================
package spc_pkg;

   // Component width of the pixel.
   localparam int PIX_W = 8;

   // Register map of the configuration port.
   typedef enum logic [1:0] {
      CSR_HUE_LOW  = 2'd0,
      CSR_HUE_HIGH = 2'd1
   } csr_index_type;

   localparam logic [PIX_W-1:0] HUE_LOW_RESET  = 8'd25;
   localparam logic [PIX_W-1:0] HUE_HIGH_RESET = 8'd230;

   // RGB rule thresholds, daylight case.
   localparam logic [PIX_W-1:0] DAY_RED_MIN   = 8'd95;
   localparam logic [PIX_W-1:0] DAY_GREEN_MIN = 8'd40;
   localparam logic [PIX_W-1:0] DAY_BLUE_MIN  = 8'd20;
   localparam logic [PIX_W-1:0] DAY_SPREAD    = 8'd15;

   // RGB rule thresholds, flash case.
   localparam logic [PIX_W-1:0] FLASH_RED_MIN   = 8'd220;
   localparam logic [PIX_W-1:0] FLASH_GREEN_MIN = 8'd210;
   localparam logic [PIX_W-1:0] FLASH_BLUE_MIN  = 8'd170;
   localparam logic [PIX_W-1:0] FLASH_RG_MAX    = 8'd15;

   // Luma coefficients in Q14, with the rounding offset.
   localparam logic [13:0] Y_COEF_R = 14'd4899;
   localparam logic [13:0] Y_COEF_G = 14'd9617;
   localparam logic [13:0] Y_COEF_B = 14'd1868;
   localparam logic [21:0] Y_ROUND  = 22'd8192;

   // Chroma conversion in Q14: coefficient and offset of 128 plus rounding.
   localparam int CHROMA_T_W = 25;
   localparam logic signed [CHROMA_T_W-1:0] CR_COEF       = 25'sd11682;
   localparam logic signed [CHROMA_T_W-1:0] CB_COEF       = 25'sd9241;
   localparam logic signed [CHROMA_T_W-1:0] CHROMA_OFFSET = 25'sd2105344;

   // Chroma line bounds, scaled to integers.
   localparam int LINE_W = 26;
   localparam logic signed [LINE_W-1:0] CR_SCALE_FINE   = 26'sd10000;
   localparam logic signed [LINE_W-1:0] CR_SCALE_COARSE = 26'sd100;
   localparam logic signed [LINE_W-1:0] L1_SLOPE  = 26'sd15862;
   localparam logic signed [LINE_W-1:0] L1_OFFSET = 26'sd200000;
   localparam logic signed [LINE_W-1:0] L2_SLOPE  = 26'sd3448;
   localparam logic signed [LINE_W-1:0] L2_OFFSET = 26'sd762069;
   localparam logic signed [LINE_W-1:0] L3_SLOPE  = -26'sd45652;
   localparam logic signed [LINE_W-1:0] L3_OFFSET = 26'sd2345652;
   localparam logic signed [LINE_W-1:0] L4_SLOPE  = -26'sd115;
   localparam logic signed [LINE_W-1:0] L4_OFFSET = 26'sd30175;
   localparam logic signed [LINE_W-1:0] L5_SLOPE  = -26'sd22857;
   localparam logic signed [LINE_W-1:0] L5_OFFSET = 26'sd4328500;

   // Hue: numerator in degrees times spread, denominator 24 times spread.
   localparam int HUE_NUM_W = 17;
   localparam int HUE_DEN_W = 13;
   localparam int HUE_X_W   = 21;

   // Saturate a Q14 chroma sum to 0..255 after the floor shift.
   function automatic logic [PIX_W-1:0] chroma_sat(input logic signed [CHROMA_T_W-1:0] t);
      logic [CHROMA_T_W-15:0] q;
      q = t[CHROMA_T_W-1:14];
      if (t < 0) begin
         return '0;
      end else if (q > 11'd255) begin
         return 8'd255;
      end else begin
         return q[PIX_W-1:0];
      end
   endfunction

endpackage

/* hw/rtl/skin_pixel_classifier_core.sv */
// ============================================================================
// skin_pixel_classifier_core: per-pixel skin classifier.
// Tests an RGB pixel against an RGB rule, a Cr/Cb line-bound rule and a hue
// band rule, and passes the pixel through when all three hold, else black.
// ============================================================================
//
//   Channel   Ports                          Direction  Transfer
//   --------  -----------------------------  ---------  -------------------------
//   request   start, busy, req_*             in         start high, busy low
//   response  rsp_valid, rsp_*               out        rsp_valid high, one cycle
//   control   csr_write_enable, csr_*        in         csr_write_enable high
//
// A pixel is taken on every clock; busy is always low. Results appear one per
// pixel, in order, after the six-stage pipeline of luma, chroma and hue
// arithmetic.
// Synchronous reset clears the stage valid bits and reloads the hue limits.
// The receiver cannot stall, so the pipeline never holds.
//
module skin_pixel_classifier_core (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   // Response channel.
   output logic        rsp_valid,
   output logic        rsp_is_skin,
   output logic        rsp_rgb_rule_ok,
   output logic        rsp_chroma_rule_ok,
   output logic        rsp_hue_rule_ok,
   output logic [7:0]  rsp_masked_red,
   output logic [7:0]  rsp_masked_green,
   output logic [7:0]  rsp_masked_blue,
   // Configuration port.
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int PW = spc_pkg::PIX_W;
   localparam int TW = spc_pkg::CHROMA_T_W;
   localparam int LW = spc_pkg::LINE_W;
   localparam int NW = spc_pkg::HUE_NUM_W;
   localparam int DW = spc_pkg::HUE_DEN_W;
   localparam int XW = spc_pkg::HUE_X_W;

   // The pipeline never blocks.
   assign busy = 1'b0;

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic [PW-1:0] hue_low_ff, hue_low_in;
   logic [PW-1:0] hue_high_ff, hue_high_in;

   // Decode a register write; writes beyond the map are dropped.
   always_comb begin
      hue_low_in  = hue_low_ff;
      hue_high_in = hue_high_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            spc_pkg::CSR_HUE_LOW:  hue_low_in  = csr_wdata;
            spc_pkg::CSR_HUE_HIGH: hue_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= spc_pkg::HUE_LOW_RESET;
         hue_high_ff <= spc_pkg::HUE_HIGH_RESET;
      end else begin
         hue_low_ff  <= hue_low_in;
         hue_high_ff <= hue_high_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: luma products, channel max/min and the RGB rule.
   // ------------------------------------------------------------------------
   logic          v1_ff, v1_in;
   logic [PW-1:0] r1_ff, g1_ff, b1_ff;
   logic [PW-1:0] mx1_ff, mx1_in, mn1_ff, mn1_in;
   logic [20:0]   pr1_ff, pr1_in;
   logic [21:0]   pg1_ff, pg1_in;
   logic [18:0]   pb1_ff, pb1_in;
   logic          rgb1_ff, rgb1_in;

   always_comb begin
      logic [PW-1:0] rg;
      logic          day;
      logic          flash;
      v1_in = start & ~busy;

      mx1_in = req_red;
      if (req_green > mx1_in) mx1_in = req_green;
      if (req_blue > mx1_in) mx1_in = req_blue;
      mn1_in = req_red;
      if (req_green < mn1_in) mn1_in = req_green;
      if (req_blue < mn1_in) mn1_in = req_blue;

      pr1_in = 21'({13'd0, req_red}   * 21'(spc_pkg::Y_COEF_R));
      pg1_in = 22'({14'd0, req_green} * 22'(spc_pkg::Y_COEF_G));
      pb1_in = 19'({11'd0, req_blue}  * 19'(spc_pkg::Y_COEF_B));

      rg = (req_red > req_green) ? req_red - req_green : req_green - req_red;
      day = (req_red > spc_pkg::DAY_RED_MIN) && (req_green > spc_pkg::DAY_GREEN_MIN) &&
            (req_blue > spc_pkg::DAY_BLUE_MIN) &&
            ((mx1_in - mn1_in) > spc_pkg::DAY_SPREAD) && (rg > spc_pkg::DAY_SPREAD) &&
            (req_red > req_green) && (req_red > req_blue);
      flash = (req_red > spc_pkg::FLASH_RED_MIN) && (req_green > spc_pkg::FLASH_GREEN_MIN) &&
              (req_blue > spc_pkg::FLASH_BLUE_MIN) && (rg <= spc_pkg::FLASH_RG_MAX) &&
              (req_red > req_blue) && (req_green > req_blue);
      rgb1_in = day | flash;
   end

   // ------------------------------------------------------------------------
   // Stage 2: luma sum and hue numerator/denominator.
   // ------------------------------------------------------------------------
   logic          v2_ff;
   logic [PW-1:0] r2_ff, g2_ff, b2_ff;
   logic          rgb2_ff;
   logic [PW-1:0] y2_ff, y2_in;
   logic [NW-1:0] num2_ff, num2_in;
   logic [DW-1:0] den2_ff, den2_in;
   logic          grey2_ff, grey2_in;

   always_comb begin
      logic [21:0]        ysum;
      logic [PW-1:0]      d;
      logic signed [19:0] rs, gs, bs, ds, n;
      ysum = 22'(pr1_ff) + pg1_ff + 22'(pb1_ff) + spc_pkg::Y_ROUND;
      y2_in = ysum[21:14];

      d  = mx1_ff - mn1_ff;
      rs = $signed({12'd0, r1_ff});
      gs = $signed({12'd0, g1_ff});
      bs = $signed({12'd0, b1_ff});
      ds = $signed({12'd0, d});
      // Numerator in degrees times spread, selected by the largest channel.
      if (d == '0) begin
         n = '0;
      end else if (mx1_ff == r1_ff) begin
         n = 20'sd60 * (gs - bs);
         if (n < 0) n = n + 20'sd360 * ds;
      end else if (mx1_ff == g1_ff) begin
         n = 20'sd60 * (bs - rs) + 20'sd120 * ds;
      end else begin
         n = 20'sd60 * (rs - gs) + 20'sd240 * ds;
      end
      num2_in  = n[NW-1:0];
      den2_in  = DW'({5'd0, d} * 13'd24);
      grey2_in = (d == '0);
   end

   // ------------------------------------------------------------------------
   // Stage 3: chroma products and hue limit products.
   // The scaled hue is floor(17 N / 24 d); it is below a limit L exactly when
   // 17 N < L * 24 d, so the limits are scaled instead of dividing.
   // ------------------------------------------------------------------------
   logic                 v3_ff;
   logic [PW-1:0]        r3_ff, g3_ff, b3_ff;
   logic                 rgb3_ff;
   logic signed [TW-1:0] tcr3_ff, tcr3_in, tcb3_ff, tcb3_in;
   logic [XW-1:0]        x3_ff, x3_in, lo3_ff, lo3_in;
   logic [XW:0]          hi3_ff, hi3_in;
   logic                 grey3_ff;

   always_comb begin
      logic signed [TW-1:0] dcr, dcb;
      logic [PW:0]          high_p1;
      dcr = $signed({17'd0, r2_ff}) - $signed({17'd0, y2_ff});
      dcb = $signed({17'd0, b2_ff}) - $signed({17'd0, y2_ff});
      tcr3_in = dcr * spc_pkg::CR_COEF + spc_pkg::CHROMA_OFFSET;
      tcb3_in = dcb * spc_pkg::CB_COEF + spc_pkg::CHROMA_OFFSET;

      high_p1 = {1'b0, hue_high_ff} + 9'd1;
      x3_in  = XW'({4'd0, num2_ff} * 21'd17);
      lo3_in = XW'({13'd0, hue_low_ff} * {8'd0, den2_ff});
      hi3_in = (XW+1)'({13'd0, high_p1} * {9'd0, den2_ff});
   end

   // ------------------------------------------------------------------------
   // Stage 4: saturated Cr/Cb and the hue rule.
   // ------------------------------------------------------------------------
   logic          v4_ff;
   logic [PW-1:0] r4_ff, g4_ff, b4_ff;
   logic          rgb4_ff;
   logic [PW-1:0] cr4_ff, cr4_in, cb4_ff, cb4_in;
   logic          hue4_ff, hue4_in;

   always_comb begin
      cr4_in = spc_pkg::chroma_sat(tcr3_ff);
      cb4_in = spc_pkg::chroma_sat(tcb3_ff);
      // A grey pixel has hue zero.
      if (grey3_ff) begin
         hue4_in = (hue_low_ff != '0);
      end else begin
         hue4_in = (x3_ff < lo3_ff) || ({1'b0, x3_ff} >= hi3_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: both sides of the five chroma line bounds.
   // ------------------------------------------------------------------------
   logic                 v5_ff;
   logic [PW-1:0]        r5_ff, g5_ff, b5_ff;
   logic                 rgb5_ff, hue5_ff;
   logic signed [LW-1:0] c4_5_ff, c4_5_in, c100_5_ff, c100_5_in;
   logic signed [LW-1:0] rhs1_ff, rhs1_in, rhs2_ff, rhs2_in, rhs3_ff, rhs3_in;
   logic signed [LW-1:0] rhs4_ff, rhs4_in, rhs5_ff, rhs5_in;

   always_comb begin
      logic signed [LW-1:0] crs, cbs;
      crs = $signed({18'd0, cr4_ff});
      cbs = $signed({18'd0, cb4_ff});
      c4_5_in   = crs * spc_pkg::CR_SCALE_FINE;
      c100_5_in = crs * spc_pkg::CR_SCALE_COARSE;
      rhs1_in   = spc_pkg::L1_SLOPE * cbs + spc_pkg::L1_OFFSET;
      rhs2_in   = spc_pkg::L2_SLOPE * cbs + spc_pkg::L2_OFFSET;
      rhs3_in   = spc_pkg::L3_SLOPE * cbs + spc_pkg::L3_OFFSET;
      rhs4_in   = spc_pkg::L4_SLOPE * cbs + spc_pkg::L4_OFFSET;
      rhs5_in   = spc_pkg::L5_SLOPE * cbs + spc_pkg::L5_OFFSET;
   end

   // ------------------------------------------------------------------------
   // Stage 6: chroma compare, combined decision and the output register.
   // ------------------------------------------------------------------------
   logic          rsp_valid_ff;
   logic          skin_ff, skin_in;
   logic          rgb6_ff, hue6_ff;
   logic          chroma_ff, chroma_in;
   logic [PW-1:0] mr_ff, mr_in, mg_ff, mg_in, mb_ff, mb_in;

   always_comb begin
      chroma_in = (c4_5_ff <= rhs1_ff) && (c4_5_ff >= rhs2_ff) && (c4_5_ff >= rhs3_ff) &&
                  (c100_5_ff <= rhs4_ff) && (c4_5_ff <= rhs5_ff);
      skin_in = rgb5_ff & hue5_ff & chroma_in;
      mr_in   = skin_in ? r5_ff : '0;
      mg_in   = skin_in ? g5_ff : '0;
      mb_in   = skin_in ? b5_ff : '0;
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   // Payload registers of all stages.
   always_ff @(posedge clock) begin
      r1_ff <= req_red;
      g1_ff <= req_green;
      b1_ff <= req_blue;
      mx1_ff  <= mx1_in;
      mn1_ff  <= mn1_in;
      pr1_ff  <= pr1_in;
      pg1_ff  <= pg1_in;
      pb1_ff  <= pb1_in;
      rgb1_ff <= rgb1_in;

      r2_ff    <= r1_ff;
      g2_ff    <= g1_ff;
      b2_ff    <= b1_ff;
      rgb2_ff  <= rgb1_ff;
      y2_ff    <= y2_in;
      num2_ff  <= num2_in;
      den2_ff  <= den2_in;
      grey2_ff <= grey2_in;

      r3_ff    <= r2_ff;
      g3_ff    <= g2_ff;
      b3_ff    <= b2_ff;
      rgb3_ff  <= rgb2_ff;
      tcr3_ff  <= tcr3_in;
      tcb3_ff  <= tcb3_in;
      x3_ff    <= x3_in;
      lo3_ff   <= lo3_in;
      hi3_ff   <= hi3_in;
      grey3_ff <= grey2_ff;

      r4_ff   <= r3_ff;
      g4_ff   <= g3_ff;
      b4_ff   <= b3_ff;
      rgb4_ff <= rgb3_ff;
      cr4_ff  <= cr4_in;
      cb4_ff  <= cb4_in;
      hue4_ff <= hue4_in;

      r5_ff     <= r4_ff;
      g5_ff     <= g4_ff;
      b5_ff     <= b4_ff;
      rgb5_ff   <= rgb4_ff;
      hue5_ff   <= hue4_ff;
      c4_5_ff   <= c4_5_in;
      c100_5_ff <= c100_5_in;
      rhs1_ff   <= rhs1_in;
      rhs2_ff   <= rhs2_in;
      rhs3_ff   <= rhs3_in;
      rhs4_ff   <= rhs4_in;
      rhs5_ff   <= rhs5_in;

      skin_ff   <= skin_in;
      rgb6_ff   <= rgb5_ff;
      hue6_ff   <= hue5_ff;
      chroma_ff <= chroma_in;
      mr_ff     <= mr_in;
      mg_ff     <= mg_in;
      mb_ff     <= mb_in;
   end

   // Response ports.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_skin        = skin_ff;
   assign rsp_rgb_rule_ok    = rgb6_ff;
   assign rsp_chroma_rule_ok = chroma_ff;
   assign rsp_hue_rule_ok    = hue6_ff;
   assign rsp_masked_red     = mr_ff;
   assign rsp_masked_green   = mg_ff;
   assign rsp_masked_blue    = mb_ff;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench of skin_pixel_classifier_core.
// Pixels are sent on the request port, mostly with random gaps. Each pixel is
// classified by an independent integer model of the RGB, chroma and hue
// rules in the testbench, and every result is checked field by field against
// the oldest pending prediction. The hue limits are rewritten between phases
// while the pipeline is empty, including their extreme and overlapping values.
// ============================================================================
module tb;

   // Depth of the classifier pipeline, in clock cycles.
   localparam int PIPE_DEPTH = 6;
   // Register indexes that lie beyond the register map.
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;
   localparam int MAX_REPORTS = 10;

   // One classifier verdict, as it appears on the result ports.
   typedef struct packed {
      logic       is_skin;
      logic       rgb_ok;
      logic       chroma_ok;
      logic       hue_ok;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } skin_verdict_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic [7:0] req_red;
   logic [7:0] req_green;
   logic [7:0] req_blue;
   logic       rsp_valid;
   logic       rsp_is_skin;
   logic       rsp_rgb_rule_ok;
   logic       rsp_chroma_rule_ok;
   logic       rsp_hue_rule_ok;
   logic [7:0] rsp_masked_red;
   logic [7:0] rsp_masked_green;
   logic [7:0] rsp_masked_blue;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   // Local copy of the hue limits, kept in step with every register write.
   logic [7:0] hue_low;
   logic [7:0] hue_high;

   skin_verdict_type pending_verdicts[$];
   int               mismatch_count = 0;
   int               verdict_count = 0;
   int               skin_count = 0;
   int               pixel_count = 0;
   int               setting_count = 0;
   bit               idle_enabled = 1'b1;

   skin_pixel_classifier_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .rsp_valid          (rsp_valid),
      .rsp_is_skin        (rsp_is_skin),
      .rsp_rgb_rule_ok    (rsp_rgb_rule_ok),
      .rsp_chroma_rule_ok (rsp_chroma_rule_ok),
      .rsp_hue_rule_ok    (rsp_hue_rule_ok),
      .rsp_masked_red     (rsp_masked_red),
      .rsp_masked_green   (rsp_masked_green),
      .rsp_masked_blue    (rsp_masked_blue),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Q14 chroma value, floored and saturated to 0..255.
   function automatic int chroma_level(input int diff, input int coef);
      int t;
      t = diff * coef + 128 * 16384 + 8192;
      if (t < 0) begin
         return 0;
      end
      t = t >> 14;
      return (t > 255) ? 255 : t;
   endfunction

   // Integer model of the three skin rules for one pixel.
   function automatic skin_verdict_type classify_pixel(input logic [7:0] r8,
                                                       input logic [7:0] g8,
                                                       input logic [7:0] b8,
                                                       input logic [7:0] lo,
                                                       input logic [7:0] hi);
      int               r, g, b, mx, mn, spread, rg, y, cr, cb, c4, num, hue;
      logic             day, flash;
      skin_verdict_type v;
      r = r8;
      g = g8;
      b = b8;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      spread = mx - mn;
      rg = (r > g) ? r - g : g - r;

      // RGB rule: daylight case or flash case.
      day = (r > 95) && (g > 40) && (b > 20) && (spread > 15) && (rg > 15) &&
            (r > g) && (r > b);
      flash = (r > 220) && (g > 210) && (b > 170) && (rg <= 15) && (r > b) && (g > b);
      v.rgb_ok = day || flash;

      // Chroma rule: BT.601 Cr/Cb tested against five lines.
      y = (4899 * r + 9617 * g + 1868 * b + 8192) >> 14;
      cr = chroma_level(r - y, 11682);
      cb = chroma_level(b - y, 9241);
      c4 = cr * 10000;
      v.chroma_ok = (c4 <= 15862 * cb + 200000) && (c4 >= 3448 * cb + 762069) &&
                    (c4 >= -45652 * cb + 2345652) && (cr * 100 <= -115 * cb + 30175) &&
                    (c4 <= -22857 * cb + 4328500);

      // Hue rule: angle scaled to 0..254, grey pixels have hue zero.
      if (spread == 0) begin
         hue = 0;
      end else begin
         if (mx == r) begin
            num = 60 * (g - b);
            if (num < 0) num += 360 * spread;
         end else if (mx == g) begin
            num = 60 * (b - r) + 120 * spread;
         end else begin
            num = 60 * (r - g) + 240 * spread;
         end
         hue = (num * 17) / (24 * spread);
      end
      v.hue_ok = (hue < int'(lo)) || (hue > int'(hi));

      v.is_skin = v.rgb_ok && v.chroma_ok && v.hue_ok;
      v.red = v.is_skin ? r8 : 8'd0;
      v.green = v.is_skin ? g8 : 8'd0;
      v.blue = v.is_skin ? b8 : 8'd0;
      return v;
   endfunction

   // Send one pixel, after a random gap if enabled, and record its prediction.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      if (idle_enabled) begin
         while ($urandom_range(99) < 20) begin
            @(negedge clock);
            start <= 1'b0;
            req_red <= 8'($urandom);
            req_green <= 8'($urandom);
            req_blue <= 8'($urandom);
         end
      end
      @(negedge clock);
      start <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      // The transfer happens at the first rising edge with busy low.
      do begin
         @(posedge clock);
      end while (busy);
      pending_verdicts.push_back(classify_pixel(r, g, b, hue_low, hue_high));
      pixel_count++;
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic drain_pipeline();
      @(negedge clock);
      start <= 1'b0;
      while (pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // Write one register; indexes beyond the map leave the limits unchanged.
   task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_index <= 2'($urandom);
      csr_wdata <= 8'($urandom);
      if (idx == spc_pkg::CSR_HUE_LOW) begin
         hue_low = value;
      end else if (idx == spc_pkg::CSR_HUE_HIGH) begin
         hue_high = value;
      end
   endtask

   task automatic set_limits(input logic [7:0] lo, input logic [7:0] hi);
      write_register(spc_pkg::CSR_HUE_LOW, lo);
      write_register(spc_pkg::CSR_HUE_HIGH, hi);
      setting_count++;
   endtask

   // Mostly plausible skin tones, some flash-lit tones, a few grey pixels, the rest anything.
   task automatic send_random_pixel();
      int r, g, b, pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         r = $urandom_range(255, 96);
         g = $urandom_range(r, 40);
         b = $urandom_range(g, 20);
      end else if (pick < 70) begin
         r = $urandom_range(255, 221);
         g = $urandom_range((r + 15 > 255) ? 255 : r + 15, (r - 15 < 211) ? 211 : r - 15);
         b = $urandom_range(((r < g) ? r : g) - 1, 171);
      end else if (pick < 74) begin
         r = $urandom_range(255);
         g = r;
         b = r;
      end else begin
         r = $urandom_range(255);
         g = $urandom_range(255);
         b = $urandom_range(255);
      end
      send_pixel(8'(r), 8'(g), 8'(b));
   endtask

   // Extremes, grey pixels, saturated chroma, each hue sector and the RGB
   // rule thresholds, all under the limits left by reset.
   task automatic test_rules_directed();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd200, 8'd140, 8'd110);
      send_pixel(8'd180, 8'd120, 8'd90);
      send_pixel(8'd96, 8'd41, 8'd21);
      send_pixel(8'd95, 8'd41, 8'd21);
      send_pixel(8'd240, 8'd230, 8'd200);
      send_pixel(8'd221, 8'd211, 8'd171);
      send_pixel(8'd220, 8'd211, 8'd171);
      send_pixel(8'd255, 8'd100, 8'd200);
      send_pixel(8'd100, 8'd200, 8'd50);
      send_pixel(8'd50, 8'd100, 8'd200);
      send_pixel(8'd230, 8'd150, 8'd150);
      send_pixel(8'd1, 8'd254, 8'd1);
      drain_pipeline();
   endtask

   // Extreme and overlapping hue limits, plus writes to unmapped indexes.
   task automatic test_register_settings();
      logic [7:0] extremes[4][2];
      extremes = '{'{8'd0, 8'd255}, '{8'd255, 8'd0}, '{8'd255, 8'd255}, '{8'd0, 8'd0}};
      foreach (extremes[k]) begin
         set_limits(extremes[k][0], extremes[k][1]);
         repeat (40) send_random_pixel();
         drain_pipeline();
      end
      set_limits(8'd25, 8'd230);
      write_register(CSR_SPARE_A, 8'd255);
      write_register(CSR_SPARE_B, 8'd0);
      repeat (40) send_random_pixel();
      drain_pipeline();
   endtask

   // Random pixels over several limit settings; one phase runs back to back.
   task automatic test_random_pixels();
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 0) begin
            set_limits(8'd25, 8'd230);
         end else begin
            set_limits(8'($urandom_range(60)), 8'($urandom_range(255, 180)));
         end
         idle_enabled = (phase != 2);
         repeat (160) send_random_pixel();
         drain_pipeline();
      end
      idle_enabled = 1'b1;
   endtask

   // Check each result against the oldest prediction.
   always @(posedge clock) begin
      skin_verdict_type got;
      skin_verdict_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_is_skin, rsp_rgb_rule_ok, rsp_chroma_rule_ok, rsp_hue_rule_ok,
                 rsp_masked_red, rsp_masked_green, rsp_masked_blue};
         verdict_count++;
         if (got.is_skin) skin_count++;
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: result with no pixel pending: skin=%0b rgb=%0b chroma=%0b",
                        $time, got.is_skin, got.rgb_ok, got.chroma_ok);
            end
         end else begin
            want = pending_verdicts.pop_front();
            if (got.is_skin !== want.is_skin || got.rgb_ok !== want.rgb_ok ||
                got.chroma_ok !== want.chroma_ok || got.hue_ok !== want.hue_ok ||
                got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: result %0d mismatch", $time, verdict_count);
                  $display("   expected skin=%0b rgb=%0b chroma=%0b hue=%0b pixel=%0d,%0d,%0d",
                           want.is_skin, want.rgb_ok, want.chroma_ok, want.hue_ok,
                           want.red, want.green, want.blue);
                  $display("   actual   skin=%0b rgb=%0b chroma=%0b hue=%0b pixel=%0d,%0d,%0d",
                           got.is_skin, got.rgb_ok, got.chroma_ok, got.hue_ok,
                           got.red, got.green, got.blue);
               end
            end
         end
      end
   end

   // Run the tests in turn and report.
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_red = 8'd0;
      req_green = 8'd0;
      req_blue = 8'd0;
      csr_write_enable = 1'b0;
      csr_index = 2'd0;
      csr_wdata = 8'd0;
      hue_low = spc_pkg::HUE_LOW_RESET;
      hue_high = spc_pkg::HUE_HIGH_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_rules_directed();
      test_register_settings();
      test_random_pixels();

      $display("Sent %0d pixels under %0d limit settings plus reset values.",
               pixel_count, setting_count);
      $display("Checked %0d results, %0d classified as skin, %0d mismatches.",
               verdict_count, skin_count, mismatch_count);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("** skin_pixel_classifier_core: PASSED **");
      end else begin
         if (pending_verdicts.size() != 0) begin
            $display("%0d predicted results never arrived.", pending_verdicts.size());
         end
         $display("** skin_pixel_classifier_core: FAILED **");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2ms;
      $display("Timeout with %0d results still pending.", pending_verdicts.size());
      $display("** skin_pixel_classifier_core: FAILED **");
      $finish;
   end

endmodule
